FILE: src/assert_macros.svh
// Assertion macros shared by the vertex projection and visibility block.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising clock edge outside reset.
`define VPV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that post holds in the cycle after pre.
`define VPV_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/vpv_pkg.sv
// Shared types, widths and constants for the vertex projection and visibility block.
// No dependencies.
`default_nettype none

package vpv_pkg;

    localparam int COEF_W   = 21;
    localparam int POS_W    = 32;
    localparam int NRM_W    = 16;
    localparam int PROD_W   = 53;
    localparam int ACC_W    = 56;
    localparam int DOTP_W   = 37;
    localparam int DOT_W    = 39;
    localparam int CFG_W    = 63;
    localparam int MARGIN_W = 12;
    localparam int DIM_W    = 13;
    localparam int PIX_W    = 20;
    localparam int DIST_W   = 16;
    localparam int IDX_W    = 3;

    localparam logic signed [PIX_W-1:0] PIX_MAX = 20'sh7FFFF;
    localparam logic signed [PIX_W-1:0] PIX_MIN = 20'sh80000;
    localparam logic [DIST_W-1:0] DIST_MAX = 16'hFFFF;

    localparam logic [MARGIN_W-1:0] MARGIN_RST = 12'd300;
    localparam logic [DIM_W-1:0] WIDTH_RST = 13'd1920;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd1440;

    typedef enum logic [IDX_W-1:0] {
        CFG_COEF_A,
        CFG_COEF_B,
        CFG_COEF_C,
        CFG_COEF_D,
        CFG_VIEW_AXIS,
        CFG_EDGE_MARGIN,
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT
    } cfg_reg_t;

    typedef struct packed {
        logic valid;
        logic facing;
        logic w_zero;
        logic visible;
    } ctrl_t;

    typedef struct packed {
        logic neg;
        logic ovf;
        logic rnz;
    } div_flag_t;

    function automatic logic signed [COEF_W-1:0] coef_field(
        input logic [CFG_W-1:0] word,
        input int unsigned slot
    );
        return word[slot*COEF_W +: COEF_W];
    endfunction

endpackage

`default_nettype wire

FILE: src/vpv_xform.sv
// Matrix transform and facing test: products in one stage, sums in the next.
// Depends on vpv_pkg.
`default_nettype none

module vpv_xform #(
    parameter int POS_FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  logic in_valid,
    input  logic signed [vpv_pkg::POS_W-1:0] pos_x,
    input  logic signed [vpv_pkg::POS_W-1:0] pos_y,
    input  logic signed [vpv_pkg::POS_W-1:0] pos_z,
    input  logic signed [vpv_pkg::NRM_W-1:0] normal_x,
    input  logic signed [vpv_pkg::NRM_W-1:0] normal_y,
    input  logic signed [vpv_pkg::NRM_W-1:0] normal_z,
    input  logic [vpv_pkg::CFG_W-1:0] coef_a,
    input  logic [vpv_pkg::CFG_W-1:0] coef_b,
    input  logic [vpv_pkg::CFG_W-1:0] coef_c,
    input  logic [vpv_pkg::CFG_W-1:0] coef_d,
    input  logic [vpv_pkg::CFG_W-1:0] view_axis,
    output vpv_pkg::ctrl_t ctrl_out,
    output logic signed [vpv_pkg::ACC_W-1:0] uvw [3]
);

    logic [vpv_pkg::CFG_W-1:0] words [4];
    logic signed [vpv_pkg::COEF_W-1:0] m [12];
    logic signed [vpv_pkg::COEF_W-1:0] axis [3];
    logic signed [vpv_pkg::POS_W-1:0] pos [3];
    logic signed [vpv_pkg::NRM_W-1:0] nrm [3];
    logic signed [vpv_pkg::PROD_W-1:0] prod_next [9];
    logic signed [vpv_pkg::PROD_W-1:0] prod_reg [9];
    logic signed [vpv_pkg::DOTP_W-1:0] dotp_next [3];
    logic signed [vpv_pkg::DOTP_W-1:0] dotp_reg [3];
    logic signed [vpv_pkg::ACC_W-1:0] uvw_next [3];
    logic signed [vpv_pkg::ACC_W-1:0] uvw_reg [3];
    logic signed [vpv_pkg::DOT_W-1:0] dot_sum;
    vpv_pkg::ctrl_t s1_ctrl_reg;
    vpv_pkg::ctrl_t s1_ctrl_next;
    vpv_pkg::ctrl_t s2_ctrl_reg;
    vpv_pkg::ctrl_t s2_ctrl_next;

    always_comb
    begin
        words[0] = coef_a;
        words[1] = coef_b;
        words[2] = coef_c;
        words[3] = coef_d;
        for (int wi = 0; wi < 4; wi++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                m[wi*3+j] = vpv_pkg::coef_field(words[wi], j);
            end
        end
        for (int j = 0; j < 3; j++)
        begin
            axis[j] = vpv_pkg::coef_field(view_axis, j);
        end
        pos[0] = pos_x;
        pos[1] = pos_y;
        pos[2] = pos_z;
        nrm[0] = normal_x;
        nrm[1] = normal_y;
        nrm[2] = normal_z;
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[r*3+c] = m[r*4+c] * pos[c];
            end
            dotp_next[r] = nrm[r] * axis[r];
        end
        s1_ctrl_next = '0;
        s1_ctrl_next.valid = in_valid;
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            uvw_next[r] = vpv_pkg::ACC_W'(prod_reg[r*3])
                        + vpv_pkg::ACC_W'(prod_reg[r*3+1])
                        + vpv_pkg::ACC_W'(prod_reg[r*3+2])
                        + (vpv_pkg::ACC_W'(m[r*4+3]) <<< POS_FRAC_BITS);
        end
        dot_sum = vpv_pkg::DOT_W'(dotp_reg[0]) + vpv_pkg::DOT_W'(dotp_reg[1])
                + vpv_pkg::DOT_W'(dotp_reg[2]);
        s2_ctrl_next = s1_ctrl_reg;
        s2_ctrl_next.facing = dot_sum[vpv_pkg::DOT_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
        end
        else if (adv)
        begin
            s1_ctrl_reg <= s1_ctrl_next;
            s2_ctrl_reg <= s2_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            dotp_reg <= dotp_next;
            uvw_reg <= uvw_next;
        end
    end

    assign ctrl_out = s2_ctrl_reg;
    assign uvw = uvw_reg;

endmodule

`default_nettype wire

FILE: src/vpv_div.sv
// Pipelined restoring divider: u and v over w, one quotient bit per stage.
// Depends on vpv_pkg.
`default_nettype none

module vpv_div #(
    parameter int PIXEL_FRAC_BITS = 4,
    parameter int QB = 21
) (
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  vpv_pkg::ctrl_t ctrl_in,
    input  logic signed [vpv_pkg::ACC_W-1:0] uvw [3],
    output vpv_pkg::ctrl_t ctrl_out,
    output logic [QB-1:0] quot [2],
    output vpv_pkg::div_flag_t flag [2]
);

    localparam int NW = vpv_pkg::ACC_W + PIXEL_FRAC_BITS;

    vpv_pkg::ctrl_t ctl_reg [QB+1];
    logic [NW-1:0] rem_reg [QB+1][2];
    logic [vpv_pkg::ACC_W-1:0] den_reg [QB+1];
    logic [QB-1:0] quo_reg [QB+1][2];
    logic neg_reg [QB+1][2];
    logic ovf_reg [QB+1][2];

    logic [vpv_pkg::ACC_W-1:0] mag [3];
    logic [NW-1:0] num0 [2];
    logic ovf0 [2];
    logic neg0 [2];
    vpv_pkg::ctrl_t ctl0;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = uvw[i][vpv_pkg::ACC_W-1] ? vpv_pkg::ACC_W'(-uvw[i])
                                               : vpv_pkg::ACC_W'(uvw[i]);
        end
        for (int l = 0; l < 2; l++)
        begin
            num0[l] = NW'(mag[l]) << PIXEL_FRAC_BITS;
            ovf0[l] = (num0[l] >> QB) >= NW'(mag[2]);
            neg0[l] = uvw[l][vpv_pkg::ACC_W-1] ^ uvw[2][vpv_pkg::ACC_W-1];
        end
        ctl0 = ctrl_in;
        ctl0.w_zero = (uvw[2] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else if (adv)
        begin
            ctl_reg[0] <= ctl0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg[0] <= mag[2];
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[0][l] <= num0[l];
                quo_reg[0][l] <= '0;
                neg_reg[0][l] <= neg0[l];
                ovf_reg[0][l] <= ovf0[l];
            end
        end
    end

    for (genvar s = 1; s <= QB; s++)
    begin : g_stage
        localparam int K = QB - s;
        logic take [2];
        logic [NW-1:0] rem_n [2];
        logic [QB-1:0] quo_n [2];

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                take[l] = (rem_reg[s-1][l] >> K) >= NW'(den_reg[s-1]);
                rem_n[l] = take[l] ? rem_reg[s-1][l] - (NW'(den_reg[s-1]) << K)
                                   : rem_reg[s-1][l];
                quo_n[l] = quo_reg[s-1][l];
                quo_n[l][K] = take[l];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s] <= '0;
            end
            else if (adv)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                den_reg[s] <= den_reg[s-1];
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[s][l] <= rem_n[l];
                    quo_reg[s][l] <= quo_n[l];
                    neg_reg[s][l] <= neg_reg[s-1][l];
                    ovf_reg[s][l] <= ovf_reg[s-1][l];
                end
            end
        end
    end

    always_comb
    begin
        ctrl_out = ctl_reg[QB];
        for (int l = 0; l < 2; l++)
        begin
            quot[l] = quo_reg[QB][l];
            flag[l].neg = neg_reg[QB][l];
            flag[l].ovf = ovf_reg[QB][l];
            flag[l].rnz = (rem_reg[QB][l] != '0);
        end
    end

endmodule

`default_nettype wire

FILE: src/vpv_cls.sv
// Quotient sign fix, pixel saturation, margin test and squared center offset.
// Depends on vpv_pkg.
`default_nettype none

module vpv_cls #(
    parameter int PIXEL_FRAC_BITS = 4,
    parameter int QB = 21
) (
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  vpv_pkg::ctrl_t ctrl_in,
    input  logic [QB-1:0] quot [2],
    input  vpv_pkg::div_flag_t flag [2],
    input  logic [vpv_pkg::MARGIN_W-1:0] edge_margin,
    input  logic [vpv_pkg::DIM_W-1:0] image_width,
    input  logic [vpv_pkg::DIM_W-1:0] image_height,
    output vpv_pkg::ctrl_t ctrl_out,
    output logic signed [vpv_pkg::PIX_W-1:0] px,
    output logic signed [vpv_pkg::PIX_W-1:0] py,
    output logic [2*(14+PIXEL_FRAC_BITS)-1:0] sum_sq
);

    localparam int CW = QB + 2;
    localparam int DXW = 14 + PIXEL_FRAC_BITS;
    localparam int SQW = 2 * DXW - 1;
    localparam int SW = 2 * DXW;

    // stage 1: signed floor quotient
    logic [QB:0] tt [2];
    logic signed [QB:0] q_next [2];
    logic signed [QB:0] q_reg [2];
    vpv_pkg::div_flag_t fl_reg [2];
    vpv_pkg::ctrl_t c1_ctrl_reg;

    // stage 2: saturation and margin test
    logic signed [CW-1:0] qe [2];
    logic signed [CW-1:0] dim [2];
    logic signed [CW-1:0] lim [2];
    logic signed [CW-1:0] mg;
    logic signed [CW-1:0] dxf [2];
    logic inr [2];
    logic signed [vpv_pkg::PIX_W-1:0] pix_next [2];
    logic signed [DXW-1:0] dx_next [2];
    vpv_pkg::ctrl_t c2_ctrl_next;
    vpv_pkg::ctrl_t c2_ctrl_reg;
    logic signed [vpv_pkg::PIX_W-1:0] c2_pix_reg [2];
    logic signed [DXW-1:0] dx_reg [2];

    // stage 3: squares
    logic signed [2*DXW-1:0] sq_full [2];
    logic [SQW-1:0] sq_reg [2];
    vpv_pkg::ctrl_t c3_ctrl_reg;
    logic signed [vpv_pkg::PIX_W-1:0] c3_pix_reg [2];

    // stage 4: sum of squares
    logic [SW-1:0] sum_reg;
    vpv_pkg::ctrl_t c4_ctrl_reg;
    logic signed [vpv_pkg::PIX_W-1:0] c4_pix_reg [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            tt[l] = {1'b0, quot[l]} + (QB+1)'(flag[l].neg & flag[l].rnz);
            q_next[l] = flag[l].neg ? $signed(-tt[l]) : $signed(tt[l]);
        end
    end

    always_comb
    begin
        mg = CW'($signed({1'b0, edge_margin})) <<< PIXEL_FRAC_BITS;
        dim[0] = CW'($signed({1'b0, image_width})) <<< PIXEL_FRAC_BITS;
        dim[1] = CW'($signed({1'b0, image_height})) <<< PIXEL_FRAC_BITS;
        for (int l = 0; l < 2; l++)
        begin
            qe[l] = CW'(q_reg[l]);
            lim[l] = dim[l] - mg;
            inr[l] = !fl_reg[l].ovf && (qe[l] >= mg) && (qe[l] < lim[l]);
            priority if (c1_ctrl_reg.w_zero)
            begin
                pix_next[l] = '0;
            end
            else if (fl_reg[l].ovf)
            begin
                pix_next[l] = fl_reg[l].neg ? vpv_pkg::PIX_MIN : vpv_pkg::PIX_MAX;
            end
            else if (qe[l] > CW'(vpv_pkg::PIX_MAX))
            begin
                pix_next[l] = vpv_pkg::PIX_MAX;
            end
            else if (qe[l] < CW'(vpv_pkg::PIX_MIN))
            begin
                pix_next[l] = vpv_pkg::PIX_MIN;
            end
            else
            begin
                pix_next[l] = qe[l][vpv_pkg::PIX_W-1:0];
            end
            dxf[l] = (qe[l] <<< 1) - dim[l];
            dx_next[l] = dxf[l][DXW-1:0];
        end
        c2_ctrl_next = c1_ctrl_reg;
        c2_ctrl_next.visible = c1_ctrl_reg.facing && !c1_ctrl_reg.w_zero && inr[0] && inr[1];
    end

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            sq_full[l] = dx_reg[l] * dx_reg[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_ctrl_reg <= '0;
            c2_ctrl_reg <= '0;
            c3_ctrl_reg <= '0;
            c4_ctrl_reg <= '0;
        end
        else if (adv)
        begin
            c1_ctrl_reg <= ctrl_in;
            c2_ctrl_reg <= c2_ctrl_next;
            c3_ctrl_reg <= c2_ctrl_reg;
            c4_ctrl_reg <= c3_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 2; l++)
            begin
                q_reg[l] <= q_next[l];
                fl_reg[l] <= flag[l];
                c2_pix_reg[l] <= pix_next[l];
                dx_reg[l] <= dx_next[l];
                sq_reg[l] <= sq_full[l][SQW-1:0];
                c3_pix_reg[l] <= c2_pix_reg[l];
                c4_pix_reg[l] <= c3_pix_reg[l];
            end
            sum_reg <= SW'(sq_reg[0]) + SW'(sq_reg[1]);
        end
    end

    assign ctrl_out = c4_ctrl_reg;
    assign px = c4_pix_reg[0];
    assign py = c4_pix_reg[1];
    assign sum_sq = sum_reg;

endmodule

`default_nettype wire

FILE: src/vpv_sqrt.sv
// Pipelined integer square root, one root bit per stage, and distance output.
// Depends on vpv_pkg.
`default_nettype none

module vpv_sqrt #(
    parameter int SW = 36
) (
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  vpv_pkg::ctrl_t ctrl_in,
    input  logic [SW-1:0] sum_sq,
    input  logic signed [vpv_pkg::PIX_W-1:0] px_in,
    input  logic signed [vpv_pkg::PIX_W-1:0] py_in,
    output vpv_pkg::ctrl_t ctrl_out,
    output logic signed [vpv_pkg::PIX_W-1:0] px,
    output logic signed [vpv_pkg::PIX_W-1:0] py,
    output logic [vpv_pkg::DIST_W-1:0] distance
);

    localparam int RB = (SW + 1) / 2;
    localparam int TW = SW + 2;

    vpv_pkg::ctrl_t ctl_reg [RB];
    logic [SW-1:0] rem_reg [RB];
    logic [RB-1:0] root_reg [RB];
    logic signed [vpv_pkg::PIX_W-1:0] px_reg [RB];
    logic signed [vpv_pkg::PIX_W-1:0] py_reg [RB];

    logic [31:0] half;

    for (genvar s = 0; s < RB; s++)
    begin : g_stage
        localparam int I = RB - 1 - s;
        vpv_pkg::ctrl_t ctl_p;
        logic [SW-1:0] rem_p;
        logic [RB-1:0] root_p;
        logic signed [vpv_pkg::PIX_W-1:0] px_p;
        logic signed [vpv_pkg::PIX_W-1:0] py_p;
        logic [TW-1:0] trial;
        logic take;
        logic [SW-1:0] rem_n;
        logic [RB-1:0] root_n;

        if (s == 0)
        begin : g_first
            assign ctl_p = ctrl_in;
            assign rem_p = sum_sq;
            assign root_p = '0;
            assign px_p = px_in;
            assign py_p = py_in;
        end
        else
        begin : g_next
            assign ctl_p = ctl_reg[s-1];
            assign rem_p = rem_reg[s-1];
            assign root_p = root_reg[s-1];
            assign px_p = px_reg[s-1];
            assign py_p = py_reg[s-1];
        end

        always_comb
        begin
            trial = (TW'(root_p) << (I + 1)) + (TW'(1) << (2 * I));
            take = TW'(rem_p) >= trial;
            rem_n = take ? SW'(TW'(rem_p) - trial) : rem_p;
            root_n = root_p;
            root_n[I] = take;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s] <= '0;
            end
            else if (adv)
            begin
                ctl_reg[s] <= ctl_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s] <= rem_n;
                root_reg[s] <= root_n;
                px_reg[s] <= px_p;
                py_reg[s] <= py_p;
            end
        end
    end

    always_comb
    begin
        half = 32'(root_reg[RB-1] >> 1);
        ctrl_out = ctl_reg[RB-1];
        px = px_reg[RB-1];
        py = py_reg[RB-1];
        priority if (!ctl_reg[RB-1].visible)
        begin
            distance = '0;
        end
        else if (half > 32'(vpv_pkg::DIST_MAX))
        begin
            distance = vpv_pkg::DIST_MAX;
        end
        else
        begin
            distance = half[vpv_pkg::DIST_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: src/vertex_projection_visibility_top.sv
// Top level of the vertex projection and visibility block: config registers and pipeline.
// Depends on vpv_pkg, vpv_xform, vpv_div, vpv_cls, vpv_sqrt and assert_macros.svh.
//
// Channel   Signals                                             Direction
// config    cfg_write cfg_index cfg_data                        in
// vertex    in_valid in_ready pos_x/y/z normal_x/y/z            in
// result    out_valid out_ready in_view pixel_x/y center_distance out
//
// One vertex per cycle while no result waits. A 21-stage divider (QB) and an
// 18-stage square root (RB) make up most of the pipeline stages.
// Reset clears all valid bits and loads register defaults; no clearing pass.
// A result not taken holds every stage; in_ready drops only while it waits.
`default_nettype none
`include "assert_macros.svh"

module vertex_projection_visibility_top #(
    parameter int POS_FRAC_BITS = 16,
    parameter int PIXEL_FRAC_BITS = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write,
    input  logic [vpv_pkg::IDX_W-1:0] cfg_index,
    input  logic [vpv_pkg::CFG_W-1:0] cfg_data,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [vpv_pkg::POS_W-1:0] pos_x,
    input  logic signed [vpv_pkg::POS_W-1:0] pos_y,
    input  logic signed [vpv_pkg::POS_W-1:0] pos_z,
    input  logic signed [vpv_pkg::NRM_W-1:0] normal_x,
    input  logic signed [vpv_pkg::NRM_W-1:0] normal_y,
    input  logic signed [vpv_pkg::NRM_W-1:0] normal_z,
    output logic out_valid,
    input  logic out_ready,
    output logic in_view,
    output logic signed [vpv_pkg::PIX_W-1:0] pixel_x,
    output logic signed [vpv_pkg::PIX_W-1:0] pixel_y,
    output logic [vpv_pkg::DIST_W-1:0] center_distance
);

    localparam int QB = (PIXEL_FRAC_BITS + 15 > 21) ? PIXEL_FRAC_BITS + 15 : 21;
    localparam int SW = 2 * (14 + PIXEL_FRAC_BITS);

    logic [vpv_pkg::CFG_W-1:0] coef_a_reg;
    logic [vpv_pkg::CFG_W-1:0] coef_b_reg;
    logic [vpv_pkg::CFG_W-1:0] coef_c_reg;
    logic [vpv_pkg::CFG_W-1:0] coef_d_reg;
    logic [vpv_pkg::CFG_W-1:0] view_axis_reg;
    logic [vpv_pkg::MARGIN_W-1:0] edge_margin_reg;
    logic [vpv_pkg::DIM_W-1:0] image_width_reg;
    logic [vpv_pkg::DIM_W-1:0] image_height_reg;

    logic adv;
    vpv_pkg::ctrl_t xf_ctrl;
    logic signed [vpv_pkg::ACC_W-1:0] uvw [3];
    vpv_pkg::ctrl_t dv_ctrl;
    logic [QB-1:0] quot [2];
    vpv_pkg::div_flag_t flag [2];
    vpv_pkg::ctrl_t cl_ctrl;
    logic signed [vpv_pkg::PIX_W-1:0] cl_px;
    logic signed [vpv_pkg::PIX_W-1:0] cl_py;
    logic [SW-1:0] cl_sum;
    vpv_pkg::ctrl_t sq_ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= '0;
            coef_b_reg <= '0;
            coef_c_reg <= '0;
            coef_d_reg <= '0;
            view_axis_reg <= '0;
            edge_margin_reg <= vpv_pkg::MARGIN_RST;
            image_width_reg <= vpv_pkg::WIDTH_RST;
            image_height_reg <= vpv_pkg::HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (vpv_pkg::cfg_reg_t'(cfg_index))
                vpv_pkg::CFG_COEF_A:       coef_a_reg <= cfg_data;
                vpv_pkg::CFG_COEF_B:       coef_b_reg <= cfg_data;
                vpv_pkg::CFG_COEF_C:       coef_c_reg <= cfg_data;
                vpv_pkg::CFG_COEF_D:       coef_d_reg <= cfg_data;
                vpv_pkg::CFG_VIEW_AXIS:    view_axis_reg <= cfg_data;
                vpv_pkg::CFG_EDGE_MARGIN:  edge_margin_reg <= cfg_data[vpv_pkg::MARGIN_W-1:0];
                vpv_pkg::CFG_IMAGE_WIDTH:  image_width_reg <= cfg_data[vpv_pkg::DIM_W-1:0];
                vpv_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[vpv_pkg::DIM_W-1:0];
                default:                   coef_a_reg <= coef_a_reg;
            endcase
        end
    end

    // advance the whole pipeline unless a result waits
    assign adv = !out_valid || out_ready;
    assign in_ready = adv;

    vpv_xform #(
        .POS_FRAC_BITS(POS_FRAC_BITS)
    ) u_xform (
        .clk(clk),
        .rst_n(rst_n),
        .adv(adv),
        .in_valid(in_valid),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z),
        .normal_x(normal_x),
        .normal_y(normal_y),
        .normal_z(normal_z),
        .coef_a(coef_a_reg),
        .coef_b(coef_b_reg),
        .coef_c(coef_c_reg),
        .coef_d(coef_d_reg),
        .view_axis(view_axis_reg),
        .ctrl_out(xf_ctrl),
        .uvw(uvw)
    );

    vpv_div #(
        .PIXEL_FRAC_BITS(PIXEL_FRAC_BITS),
        .QB(QB)
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .adv(adv),
        .ctrl_in(xf_ctrl),
        .uvw(uvw),
        .ctrl_out(dv_ctrl),
        .quot(quot),
        .flag(flag)
    );

    vpv_cls #(
        .PIXEL_FRAC_BITS(PIXEL_FRAC_BITS),
        .QB(QB)
    ) u_cls (
        .clk(clk),
        .rst_n(rst_n),
        .adv(adv),
        .ctrl_in(dv_ctrl),
        .quot(quot),
        .flag(flag),
        .edge_margin(edge_margin_reg),
        .image_width(image_width_reg),
        .image_height(image_height_reg),
        .ctrl_out(cl_ctrl),
        .px(cl_px),
        .py(cl_py),
        .sum_sq(cl_sum)
    );

    vpv_sqrt #(
        .SW(SW)
    ) u_sqrt (
        .clk(clk),
        .rst_n(rst_n),
        .adv(adv),
        .ctrl_in(cl_ctrl),
        .sum_sq(cl_sum),
        .px_in(cl_px),
        .py_in(cl_py),
        .ctrl_out(sq_ctrl),
        .px(pixel_x),
        .py(pixel_y),
        .distance(center_distance)
    );

    assign out_valid = sq_ctrl.valid;
    assign in_view = sq_ctrl.visible;

    `VPV_ASSERT(a_dist_zero_hidden, out_valid && !in_view |-> center_distance == '0, "distance set on hidden vertex")
    `VPV_ASSERT(a_view_pixel_nonneg, out_valid && in_view |-> !pixel_x[19] && !pixel_y[19], "visible pixel negative")
    `VPV_ASSERT_NEXT(a_stall_holds_result, !in_ready, out_valid, "stall without pending result")

endmodule

`default_nettype wire

FILE: sim/vpv_checker.sv
// Result checker for the vertex projection and visibility block: predicts every accepted
// vertex from the configuration writes it observes and compares each accepted result.
// Depends on vpv_pkg for widths and register codes.
`timescale 1ns / 100ps

module vpv_checker
    import vpv_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [IDX_W-1:0]            cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic signed [POS_W-1:0]     pos_x,
    input  logic signed [POS_W-1:0]     pos_y,
    input  logic signed [POS_W-1:0]     pos_z,
    input  logic signed [NRM_W-1:0]     normal_x,
    input  logic signed [NRM_W-1:0]     normal_y,
    input  logic signed [NRM_W-1:0]     normal_z,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        in_view,
    input  logic signed [PIX_W-1:0]     pixel_x,
    input  logic signed [PIX_W-1:0]     pixel_y,
    input  logic [DIST_W-1:0]           center_distance,
    output int                          errors,
    output int                          pending,
    output int                          checked,
    output int                          seen_in_view,
    output int                          seen_w_zero
);

    localparam int PIX_SCALE = 16;
    localparam longint ONE_POS = 64'sd65536;

    typedef struct {
        logic                    in_view;
        logic signed [PIX_W-1:0] px;
        logic signed [PIX_W-1:0] py;
        logic [DIST_W-1:0]       distance;
        logic                    w_zero;
    } vertex_result_t;

    vertex_result_t     expected_results[$];
    logic [CFG_W-1:0]   coef_a, coef_b, coef_c, coef_d, axis;
    logic [MARGIN_W-1:0] margin;
    logic [DIM_W-1:0]   width, height;

    function automatic longint coef_at(logic [CFG_W-1:0] word, int slot);
        logic signed [COEF_W-1:0] f;
        f = word[slot*COEF_W +: COEF_W];
        return longint'(f);
    endfunction

    function automatic longint div_floor(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && ((a < 0) != (b < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned s);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > s)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (s >= r + bitv)
            begin
                s = s - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [PIX_W-1:0] clamp_pixel(longint p);
        longint c;
        c = p;
        if (p > 524287)
            c = 524287;
        else if (p < -524288)
            c = -524288;
        return c[PIX_W-1:0];
    endfunction

    function automatic vertex_result_t project_vertex(
        longint x, longint y, longint z, longint nx, longint ny, longint nz);
        vertex_result_t r;
        longint u, v, w, dot, px, py, mg, wl, hl, dx, dy;
        longint unsigned s, d;
        logic facing, xin, yin;
        u = coef_at(coef_a, 0) * x + coef_at(coef_a, 1) * y + coef_at(coef_a, 2) * z
            + coef_at(coef_b, 0) * ONE_POS;
        v = coef_at(coef_b, 1) * x + coef_at(coef_b, 2) * y + coef_at(coef_c, 0) * z
            + coef_at(coef_c, 1) * ONE_POS;
        w = coef_at(coef_c, 2) * x + coef_at(coef_d, 0) * y + coef_at(coef_d, 1) * z
            + coef_at(coef_d, 2) * ONE_POS;
        dot = nx * coef_at(axis, 0) + ny * coef_at(axis, 1) + nz * coef_at(axis, 2);
        facing = dot < 0;
        r.in_view = 1'b0;
        r.distance = '0;
        r.w_zero = (w == 0);
        px = 0;
        py = 0;
        if (w != 0)
        begin
            px = div_floor(u * PIX_SCALE, w);
            py = div_floor(v * PIX_SCALE, w);
            mg = longint'(margin) * PIX_SCALE;
            wl = longint'(width) * PIX_SCALE;
            hl = longint'(height) * PIX_SCALE;
            xin = (px >= mg) && (px < wl - mg);
            yin = (py >= mg) && (py < hl - mg);
            r.in_view = facing && xin && yin;
            if (r.in_view)
            begin
                dx = 2 * px - wl;
                dy = 2 * py - hl;
                s = longint'(dx * dx) + longint'(dy * dy);
                d = root_floor(s) >> 1;
                r.distance = (d > 65535) ? 16'hFFFF : d[DIST_W-1:0];
            end
        end
        r.px = clamp_pixel(px);
        r.py = clamp_pixel(py);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vertex_result_t exp_r;
        if (!rst_n)
        begin
            coef_a = '0;
            coef_b = '0;
            coef_c = '0;
            coef_d = '0;
            axis = '0;
            margin = MARGIN_RST;
            width = WIDTH_RST;
            height = HEIGHT_RST;
            expected_results.delete();
            errors = 0;
            checked = 0;
            seen_in_view = 0;
            seen_w_zero = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_COEF_A:       coef_a = cfg_data;
                    CFG_COEF_B:       coef_b = cfg_data;
                    CFG_COEF_C:       coef_c = cfg_data;
                    CFG_COEF_D:       coef_d = cfg_data;
                    CFG_VIEW_AXIS:    axis = cfg_data;
                    CFG_EDGE_MARGIN:  margin = cfg_data[MARGIN_W-1:0];
                    CFG_IMAGE_WIDTH:  width = cfg_data[DIM_W-1:0];
                    CFG_IMAGE_HEIGHT: height = cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_results.push_back(project_vertex(pos_x, pos_y, pos_z,
                    normal_x, normal_y, normal_z));
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected result view=%0b px=%0d py=%0d dist=%0d",
                            in_view, pixel_x, pixel_y, center_distance);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    checked++;
                    if (exp_r.in_view)
                        seen_in_view++;
                    if (exp_r.w_zero)
                        seen_w_zero++;
                    if (in_view !== exp_r.in_view || pixel_x !== exp_r.px
                        || pixel_y !== exp_r.py || center_distance !== exp_r.distance)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("ERROR: result %0d exp view=%0b px=%0d py=%0d dist=%0d %s",
                                checked, exp_r.in_view, exp_r.px, exp_r.py, exp_r.distance,
                                $sformatf("got view=%0b px=%0d py=%0d dist=%0d",
                                    in_view, pixel_x, pixel_y, center_distance));
                    end
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

FILE: sim/vertex_projection_visibility_top_test.sv
// Testbench top for the vertex projection and visibility block: clock, reset, register
// writes, vertex stimulus with bursts and result stalls, and the final verdict.
// Depends on vpv_pkg, vertex_projection_visibility_top and vpv_checker.
`timescale 1ns / 100ps

module vertex_projection_visibility_top_test;
    import vpv_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS = 220;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid, in_ready, out_valid, out_ready, in_view;
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic signed [NRM_W-1:0] normal_x, normal_y, normal_z;
    logic signed [PIX_W-1:0] pixel_x, pixel_y;
    logic [DIST_W-1:0] center_distance;
    int errors, pending, checked, seen_in_view, seen_w_zero;
    int cycles, burst_left, settings_used;
    bit hold_go, hold_done;

    vertex_projection_visibility_top u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .out_valid(out_valid), .out_ready(out_ready), .in_view(in_view),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .center_distance(center_distance)
    );

    vpv_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .out_valid(out_valid), .out_ready(out_ready), .in_view(in_view),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .center_distance(center_distance),
        .errors(errors), .pending(pending), .checked(checked),
        .seen_in_view(seen_in_view), .seen_w_zero(seen_w_zero)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int srange(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic logic [CFG_W-1:0] pack3(int a, int b, int c);
        return {c[COEF_W-1:0], b[COEF_W-1:0], a[COEF_W-1:0]};
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic write_all(logic [CFG_W-1:0] a, logic [CFG_W-1:0] b, logic [CFG_W-1:0] c,
        logic [CFG_W-1:0] d, logic [CFG_W-1:0] ax, int mg, int wd, int ht);
        write_reg(CFG_COEF_A, a);
        write_reg(CFG_COEF_B, b);
        write_reg(CFG_COEF_C, c);
        write_reg(CFG_COEF_D, d);
        write_reg(CFG_VIEW_AXIS, ax);
        write_reg(CFG_EDGE_MARGIN, CFG_W'(mg));
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(wd));
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(ht));
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // pinhole camera with w = z / 4 so that large principal points still fit
    task automatic write_camera(int f, int cx, int cy, logic [CFG_W-1:0] ax,
        int mg, int wd, int ht);
        write_all(pack3(f * 256, 0, cx * 256), pack3(0, 0, f * 256), pack3(cy * 256, 0, 0),
            pack3(0, 256, 0), ax, mg, wd, ht);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_vertex(int x, int y, int z, int nx, int ny, int nz);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 60);
        end
        in_valid <= 1'b1;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        normal_x <= NRM_W'(nx);
        normal_y <= NRM_W'(ny);
        normal_z <= NRM_W'(nz);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_random(bit wild);
        int z, x, y, nz;
        if (wild || $urandom_range(9) == 0)
            send_vertex($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
        begin
            z = srange(65536 / 4, 8 * 65536);
            x = srange(-(z / 5) * 6, (z / 5) * 6);
            y = srange(-(z / 5) * 6, (z / 5) * 6);
            nz = ($urandom_range(3) == 0) ? srange(0, 32767) : srange(-32768, -1);
            send_vertex(x, y, z, srange(-32768, 32767), srange(-32768, 32767), nz);
        end
    endtask

    task automatic random_phase(bit wild);
        repeat (PHASE_ITEMS) send_random(wild);
        drain();
    endtask

    initial
    begin
        logic [CFG_W-1:0] axis_z, pixel_a, pixel_b, pixel_c, pixel_d;
        axis_z = pack3(0, 0, 524288);
        pixel_a = pack3(1024, 0, 0);
        pixel_b = pack3(0, 0, 1024);
        pixel_c = pack3(0, 0, 0);
        pixel_d = pack3(0, 1024, 0);
        rst_n = 1'b0;
        cycles = 0;
        burst_left = 0;
        settings_used = 1;
        hold_go = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        normal_x = '0;
        normal_y = '0;
        normal_z = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients give zero w for every vertex
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32767, -32768, 32767);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, -32768, 32767, -32768);
        send_vertex(0, 0, 65536, 0, 0, -16384);
        drain();

        // unit camera: pixel equals position with z at one
        write_all(pixel_a, pixel_b, pixel_c, pixel_d, axis_z, 300, 1920, 1440);
        send_vertex(960 << 16, 720 << 16, 65536, 0, 0, -16384);
        send_vertex(300 << 16, 720 << 16, 65536, 0, 0, -16384);
        send_vertex((300 << 16) - 1, 720 << 16, 65536, 0, 0, -16384);
        send_vertex(1620 << 16, 720 << 16, 65536, 0, 0, -16384);
        send_vertex((1620 << 16) - 1, 720 << 16, 65536, 0, 0, -16384);
        send_vertex(960 << 16, 300 << 16, 65536, 0, 0, -16384);
        send_vertex(960 << 16, (300 << 16) - 1, 65536, 0, 0, -16384);
        send_vertex(960 << 16, 1140 << 16, 65536, 0, 0, -16384);
        send_vertex(960 << 16, (1140 << 16) - 1, 65536, 0, 0, -16384);
        send_vertex(30000 << 16, -(30000 << 16), 1, 0, 0, -16384);
        send_vertex(-1, -1, 65536, 0, 0, -16384);
        send_vertex(500 << 16, 500 << 16, 0, 0, 0, -16384);
        send_vertex(-(960 << 16), -(720 << 16), -65536, 0, 0, -16384);
        send_vertex(960 << 16, 720 << 16, 65536, 0, 0, 16384);
        send_vertex(960 << 16, 720 << 16, 65536, 16384, 0, 0);
        send_vertex(400 << 16, 1000 << 16, 65536, 32767, -32768, -32768);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 32767);
        drain();

        // margin of exactly half the width leaves no visible column
        write_all(pixel_a, pixel_b, pixel_c, pixel_d, axis_z, 960, 1920, 1440);
        send_vertex(960 << 16, 720 << 16, 65536, 0, 0, -16384);
        drain();
        write_all(pixel_a, pixel_b, pixel_c, pixel_d, axis_z, 719, 1920, 1440);
        send_vertex(960 << 16, 720 << 16, 65536, 0, 0, -16384);
        drain();

        hold_go = 1'b1;
        write_camera(1000, 960, 720, axis_z, 300, 1920, 1440);
        random_phase(1'b0);
        write_camera(1500, 2047, 2047, axis_z, 0, 4096, 4096);
        random_phase(1'b0);
        write_camera(-900, 320, 240, pack3(-1048576, 1048575, -1048576), 10, 640, 480);
        random_phase(1'b0);
        write_all(CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}),
            CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}),
            CFG_W'({$urandom, $urandom}), 4095, 8191, 8191);
        random_phase(1'b1);
        write_all({63{1'b1}}, {1'b0, {62{1'b1}}}, {63{1'b1}}, pack3(-1048576, 1048575, 0),
            {63{1'b1}}, 2048, 4096, 4096);
        random_phase(1'b1);
        write_camera(8, 0, 0, axis_z, 0, 1, 0);
        random_phase(1'b0);

        $display("Covered %0d vertices over %0d register settings: %0d in view, %0d zero w.",
            checked, settings_used, seen_in_view, seen_w_zero);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int seg, mode, k;
        out_ready = 1'b0;
        hold_done = 1'b0;
        k = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_go && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                seg = $urandom_range(20, 120);
                mode = $urandom_range(2);
                repeat (seg)
                begin
                    k++;
                    case (mode)
                        0: out_ready <= 1'b1;
                        1: out_ready <= 1'($urandom_range(1));
                        default: out_ready <= (k % 5) < 3;
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

endmodule

FILE: vertex_projection_visibility_top.f
+incdir+src
src/vpv_pkg.sv
src/vpv_xform.sv
src/vpv_div.sv
src/vpv_cls.sv
src/vpv_sqrt.sv
src/vertex_projection_visibility_top.sv
sim/vpv_checker.sv
sim/vertex_projection_visibility_top_test.sv
